// ----- hw/rtl/rfc_pkg.sv -----
// reply frame checker package: result type, fail reasons, byte codes, hex decode
// no dependencies; used by rfc_frame, rfc_out_buf and reply_frame_checker_xor_hex

package rfc_pkg;

	// frame byte codes
	localparam logic [7:0] STX        = 8'h02;
	localparam logic [7:0] ETX        = 8'h03;
	localparam logic [7:0] NUL        = 8'h00;
	localparam logic [7:0] COLON      = 8'h3a;
	localparam logic [7:0] AXIS_RESET = 8'h31;

	// body positions and limits
	localparam logic [7:0] BUFFER_BYTES = 8'd128;
	localparam logic [7:0] POS_AXIS     = 8'd0;
	localparam logic [7:0] POS_STATUS   = 8'd2;
	localparam logic [7:0] POS_SPARE    = 8'd4;
	localparam logic [7:0] MIN_BODY     = 8'd7;

	// hex decode offsets
	localparam logic [7:0] HEX_ALPHA_OFS = 8'h37;
	localparam logic [7:0] HEX_DIGIT_OFS = 8'h30;
	localparam logic [7:0] HEX_ALPHA_LO  = 8'h40;
	localparam logic [7:0] HEX_ALPHA_HI  = 8'h80;

	typedef enum logic [2:0] {
		REASON_OK       = 3'd0,
		REASON_NO_STX   = 3'd1,
		REASON_NO_ETX   = 3'd2,
		REASON_AXIS     = 3'd3,
		REASON_SHORT    = 3'd4,
		REASON_CHECKSUM = 3'd5
	} reason_t;

	typedef struct packed {
		logic       data_valid;
		logic [7:0] data_byte;
		logic       frame_done;
		logic       frame_ok;
		logic [7:0] status_byte;
		reason_t    fail_reason;
	} res_t;

	// one hex character, no validation, wraps at 8 bits
	function automatic logic [7:0] hex_nibble(input logic [7:0] b);
		if (b > HEX_ALPHA_LO && b < HEX_ALPHA_HI) begin
			return b - HEX_ALPHA_OFS;
		end
		return b - HEX_DIGIT_OFS;
	endfunction

	// two hex characters into one byte
	function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
		logic [7:0] h;
		h = hex_nibble(hi);
		return {h[3:0], 4'h0} + hex_nibble(lo);
	endfunction

endpackage

// ----- hw/rtl/reply_frame_checker_xor_hex.sv -----
// top level of the reply frame checker: ports, config channel, assertions
// depends on rfc_pkg, rfc_frame and rfc_out_buf
//
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    rx_byte, buffer_last
// out       output     out_valid / out_ready  data_valid, data_byte, frame_done,
//                                             frame_ok, status_byte, fail_reason
// cfg       input      cfg_valid / cfg_ready  expected_axis
//
// one received byte is taken per clock while in_ready is high, so throughput is one
// byte a cycle; its result, if any, is registered in the result buffer
// a two-entry result buffer (result register plus skid stage) lets input keep flowing
// while a result waits; in_ready drops only when both entries hold results
// cfg_ready is always high; reset puts the checker in stx hunt with expected_axis '1'

module reply_frame_checker_xor_hex (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       buffer_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       data_valid,
	output logic [7:0] data_byte,
	output logic       frame_done,
	output logic       frame_ok,
	output logic [7:0] status_byte,
	output logic [2:0] fail_reason,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] expected_axis
);

	logic          accept;
	logic          res_valid;
	rfc_pkg::res_t res;
	rfc_pkg::res_t out_res;
	logic          space;

	assign cfg_ready = 1'b1;
	assign in_ready  = space;
	assign accept    = in_valid && space;

	// frame logic
	rfc_frame u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.rx_byte     (rx_byte),
		.buffer_last (buffer_last),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_axis    (expected_axis),
		.res_valid   (res_valid),
		.res         (res)
	);

	// result buffer
	rfc_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_res  (res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign data_valid  = out_res.data_valid;
	assign data_byte   = out_res.data_byte;
	assign frame_done  = out_res.frame_done;
	assign frame_ok    = out_res.frame_ok;
	assign status_byte = out_res.status_byte;
	assign fail_reason = out_res.fail_reason;

	// a result is either a data byte or a verdict, never both
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot({data_valid, frame_done}))
		else $error("result is not exactly one of data and verdict");

	// a pass carries reason ok, a fail carries zero status
	a_ok_reason: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_done) |->
			(frame_ok == (fail_reason == rfc_pkg::REASON_OK)) &&
			(frame_ok || status_byte == 8'd0))
		else $error("verdict fields disagree");

	// input stalls only when the result register is occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty result register");

endmodule

// ----- hw/rtl/rfc_frame.sv -----
// frame state machine: stx hunt, body tracking, running xor, data delay, verdict
// depends on rfc_pkg

module rfc_frame (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    rx_byte,
	input  logic          buffer_last,
	input  logic          cfg_we,
	input  logic [7:0]    cfg_axis,
	output logic          res_valid,
	output rfc_pkg::res_t res
);

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_BODY = 2'd1,
		PH_WAIT = 2'd2
	} phase_t;

	phase_t     phase_q, phase_n;
	logic [7:0] count_q, count_n;
	logic [7:0] xor_q, xor_n;
	logic [7:0] r0_q, r1_q, r2_q, r0_n, r1_n, r2_n;
	logic [7:0] status_q, status_n;
	logic       axis_ok_q, axis_ok_n;
	logic       suppress_q, suppress_n;
	logic [7:0] axis_q;
	logic       res_hit;
	logic       ended;
	logic       axis_now;
	logic [7:0] calc_sum;
	logic [7:0] got_sum;
	phase_t     after_body;

	assign ended      = buffer_last || (rx_byte == rfc_pkg::NUL);
	assign after_body = buffer_last ? PH_HUNT : PH_WAIT;
	assign calc_sum   = xor_q ^ r0_q ^ r1_q;
	assign got_sum    = rfc_pkg::hex_pair(r1_q, r0_q);
	assign axis_now   = (count_q == rfc_pkg::POS_AXIS) ? (rx_byte == axis_q) : axis_ok_q;

	// next state and result for the byte on the input
	always_comb begin
		phase_n    = phase_q;
		count_n    = count_q;
		xor_n      = xor_q;
		r0_n       = r0_q;
		r1_n       = r1_q;
		r2_n       = r2_q;
		status_n   = status_q;
		axis_ok_n  = axis_ok_q;
		suppress_n = suppress_q;
		res_hit    = 1'b0;
		res        = '0;
		unique case (phase_q)
			PH_HUNT: begin
				if (rx_byte == rfc_pkg::STX) begin
					count_n    = '0;
					xor_n      = '0;
					r0_n       = '0;
					r1_n       = '0;
					r2_n       = '0;
					status_n   = '0;
					axis_ok_n  = 1'b0;
					suppress_n = 1'b0;
					if (buffer_last) begin
						res_hit         = 1'b1;
						res.frame_done  = 1'b1;
						res.fail_reason = rfc_pkg::REASON_NO_ETX;
					end else begin
						phase_n = PH_BODY;
					end
				end else if (ended) begin
					phase_n         = after_body;
					res_hit         = 1'b1;
					res.frame_done  = 1'b1;
					res.fail_reason = rfc_pkg::REASON_NO_STX;
				end
			end
			PH_BODY: begin
				if (rx_byte == rfc_pkg::ETX) begin
					// end of body: verdict
					phase_n        = after_body;
					res_hit        = 1'b1;
					res.frame_done = 1'b1;
					priority if (!axis_now) begin
						res.fail_reason = rfc_pkg::REASON_AXIS;
					end else if (count_q < rfc_pkg::MIN_BODY) begin
						res.fail_reason = rfc_pkg::REASON_SHORT;
					end else if (calc_sum != got_sum) begin
						res.fail_reason = rfc_pkg::REASON_CHECKSUM;
					end else begin
						res.frame_ok    = 1'b1;
						res.status_byte = status_q;
						res.fail_reason = rfc_pkg::REASON_OK;
					end
				end else if (rx_byte == rfc_pkg::NUL) begin
					phase_n         = after_body;
					res_hit         = 1'b1;
					res.frame_done  = 1'b1;
					res.fail_reason = rfc_pkg::REASON_NO_ETX;
				end else begin
					// ordinary body byte
					axis_ok_n = axis_now;
					if (count_q == rfc_pkg::POS_STATUS) begin
						status_n = rfc_pkg::hex_pair(r0_q, rx_byte);
					end
					if (count_q == rfc_pkg::POS_SPARE) begin
						suppress_n = (rx_byte == rfc_pkg::COLON);
					end
					xor_n = xor_q ^ rx_byte;
					r2_n  = r1_q;
					r1_n  = r0_q;
					r0_n  = rx_byte;
					if (count_q < rfc_pkg::BUFFER_BYTES) begin
						count_n = count_q + 8'd1;
					end
					if (buffer_last) begin
						phase_n         = PH_HUNT;
						res_hit         = 1'b1;
						res.frame_done  = 1'b1;
						res.fail_reason = rfc_pkg::REASON_NO_ETX;
					end else if (count_q >= rfc_pkg::MIN_BODY && axis_ok_n && !suppress_n) begin
						res_hit        = 1'b1;
						res.data_valid = 1'b1;
						res.data_byte  = r2_q;
					end
				end
			end
			PH_WAIT: begin
				if (buffer_last) begin
					phase_n = PH_HUNT;
				end
			end
			default: begin
				phase_n = PH_HUNT;
			end
		endcase
	end

	assign res_valid = accept && res_hit;

	// state registers and axis register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			count_q    <= '0;
			xor_q      <= '0;
			r0_q       <= '0;
			r1_q       <= '0;
			r2_q       <= '0;
			status_q   <= '0;
			axis_ok_q  <= 1'b0;
			suppress_q <= 1'b0;
			axis_q     <= rfc_pkg::AXIS_RESET;
		end else begin
			if (accept) begin
				phase_q    <= phase_n;
				count_q    <= count_n;
				xor_q      <= xor_n;
				r0_q       <= r0_n;
				r1_q       <= r1_n;
				r2_q       <= r2_n;
				status_q   <= status_n;
				axis_ok_q  <= axis_ok_n;
				suppress_q <= suppress_n;
			end
			if (cfg_we) begin
				axis_q <= cfg_axis;
			end
		end
	end

endmodule

// ----- hw/rtl/rfc_out_buf.sv -----
// result register with skid stage between the frame logic and the output port
// depends on rfc_pkg

module rfc_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rfc_pkg::res_t push_res,
	output logic          space,
	output logic          out_valid,
	input  logic          out_ready,
	output rfc_pkg::res_t out_res
);

	logic          out_valid_q;
	logic          skid_valid_q;
	rfc_pkg::res_t out_q;
	rfc_pkg::res_t skid_q;
	logic          pop;

	assign pop       = out_valid_q && out_ready;
	assign space     = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// output register refills from skid first, new results go behind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
			out_q        <= '0;
			skid_q       <= '0;
		end else begin
			if (!out_valid_q || pop) begin
				if (skid_valid_q) begin
					out_q        <= skid_q;
					out_valid_q  <= 1'b1;
					skid_valid_q <= push;
					skid_q       <= push_res;
				end else begin
					out_valid_q <= push;
					out_q       <= push_res;
				end
			end else if (push) begin
				skid_q       <= push_res;
				skid_valid_q <= 1'b1;
			end
		end
	end

endmodule

// ----- sim/tb_reply_frame_checker_xor_hex.sv -----
// testbench for reply_frame_checker_xor_hex: streams reply buffers under random idling
// and stalls, predicts every data byte and verdict, checks them in order
// depends on rfc_pkg and the reply_frame_checker_xor_hex rtl

module tb_reply_frame_checker_xor_hex;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 80;
	localparam int IDLE_PCT    = 6;
	localparam int SETTLE      = 4;

	typedef enum logic [1:0] {HUNT, IN_BODY, DRAIN} rx_phase_t;
	typedef enum int {GOOD_FRAME, BAD_SUM, COLON_DATA, WRONG_AXIS} frame_kind_t;

	typedef struct {
		logic [7:0] b;
		logic       last;
	} rx_req_t;

	logic       clk;
	logic       arst_n        = 1'b0;
	logic       in_valid      = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte       = '0;
	logic       buffer_last   = 1'b0;
	logic       out_valid;
	logic       out_ready     = 1'b0;
	logic       data_valid;
	logic [7:0] data_byte;
	logic       frame_done;
	logic       frame_ok;
	logic [7:0] status_byte;
	logic [2:0] fail_reason;
	logic       cfg_valid     = 1'b0;
	logic       cfg_ready;
	logic [7:0] expected_axis = rfc_pkg::AXIS_RESET;

	// request streams and bookkeeping
	rx_req_t        rx_pending[$];
	rfc_pkg::res_t  frame_results_due[$];
	bit         byte_taken  = 0;
	bit         hold_rx     = 0;
	bit         squeeze_go  = 0;
	int         n_pushed    = 0;
	int         n_bytes     = 0;
	int         n_data      = 0;
	int         n_verdicts  = 0;
	int         n_cfg       = 0;
	int         mismatches  = 0;
	int         quiet_count = 0;

	// predicted checker state
	rx_phase_t  rx_phase   = HUNT;
	logic [7:0] body_len   = '0;
	logic [7:0] body_xor   = '0;
	logic [7:0] tail [0:2] = '{default: '0};
	logic [7:0] held_status = '0;
	logic       axis_ok    = 1'b0;
	logic       colon_seen = 1'b0;
	logic [7:0] want_axis  = rfc_pkg::AXIS_RESET;

	wire quiet_spell = n_bytes >= 350 && n_bytes < 450;

	reply_frame_checker_xor_hex dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.buffer_last   (buffer_last),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.data_valid    (data_valid),
		.data_byte     (data_byte),
		.frame_done    (frame_done),
		.frame_ok      (frame_ok),
		.status_byte   (status_byte),
		.fail_reason   (fail_reason),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.expected_axis (expected_axis)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// hex character value, letters from just above '@', no validation
	function automatic logic [7:0] hex_digit_value(input logic [7:0] c);
		if (c > rfc_pkg::HEX_ALPHA_LO && c < rfc_pkg::HEX_ALPHA_HI) begin
			return c - rfc_pkg::HEX_ALPHA_OFS;
		end
		return c - rfc_pkg::HEX_DIGIT_OFS;
	endfunction

	function automatic logic [7:0] hex_to_byte(input logic [7:0] hi, input logic [7:0] lo);
		logic [7:0] h;
		h = hex_digit_value(hi);
		return {h[3:0], 4'h0} + hex_digit_value(lo);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		return (nib < 4'd10) ? rfc_pkg::HEX_DIGIT_OFS + nib : rfc_pkg::HEX_ALPHA_OFS + nib;
	endfunction

	// advance the predicted checker by one received byte, 1 when a result is due
	function automatic bit check_rx_byte(input logic [7:0] b, input logic last,
			output rfc_pkg::res_t r);
		logic [7:0]       k;
		logic [7:0]       sent;
		logic [7:0]       calc;
		rfc_pkg::reason_t why;
		bit               fire;
		r = '0;
		if (rx_phase == HUNT) begin
			if (b == rfc_pkg::STX) begin
				body_len    = '0;
				body_xor    = '0;
				tail        = '{default: '0};
				held_status = '0;
				axis_ok     = 1'b0;
				colon_seen  = 1'b0;
				if (last) begin
					r.frame_done  = 1'b1;
					r.fail_reason = rfc_pkg::REASON_NO_ETX;
					return 1;
				end
				rx_phase = IN_BODY;
				return 0;
			end
			if (last || b == rfc_pkg::NUL) begin
				rx_phase      = last ? HUNT : DRAIN;
				r.frame_done  = 1'b1;
				r.fail_reason = rfc_pkg::REASON_NO_STX;
				return 1;
			end
			return 0;
		end
		if (rx_phase == IN_BODY) begin
			// end of body: axis, length, then checksum against the trailing hex pair
			if (b == rfc_pkg::ETX) begin
				why = rfc_pkg::REASON_OK;
				if (body_len == 0) begin
					axis_ok = (b == want_axis);
				end
				if (!axis_ok) begin
					why = rfc_pkg::REASON_AXIS;
				end else if (body_len < rfc_pkg::MIN_BODY) begin
					why = rfc_pkg::REASON_SHORT;
				end else begin
					calc = body_xor ^ tail[0] ^ tail[1];
					if (calc != hex_to_byte(tail[1], tail[0])) begin
						why = rfc_pkg::REASON_CHECKSUM;
					end else begin
						r.status_byte = held_status;
					end
				end
				rx_phase      = last ? HUNT : DRAIN;
				r.frame_done  = 1'b1;
				r.frame_ok    = (why == rfc_pkg::REASON_OK);
				r.fail_reason = why;
				return 1;
			end
			if (b == rfc_pkg::NUL) begin
				rx_phase      = last ? HUNT : DRAIN;
				r.frame_done  = 1'b1;
				r.fail_reason = rfc_pkg::REASON_NO_ETX;
				return 1;
			end
			k    = body_len;
			sent = tail[2];
			if (k == rfc_pkg::POS_AXIS) begin
				axis_ok = (b == want_axis);
			end else if (k == rfc_pkg::POS_STATUS) begin
				held_status = hex_to_byte(tail[0], b);
			end else if (k == rfc_pkg::POS_SPARE) begin
				colon_seen = (b == rfc_pkg::COLON);
			end
			fire     = k >= rfc_pkg::MIN_BODY && axis_ok && !colon_seen;
			body_xor = body_xor ^ b;
			tail[2]  = tail[1];
			tail[1]  = tail[0];
			tail[0]  = b;
			if (body_len < rfc_pkg::BUFFER_BYTES) begin
				body_len = body_len + 8'd1;
			end
			// buffer end on a body byte replaces its data result
			if (last) begin
				rx_phase      = HUNT;
				r.frame_done  = 1'b1;
				r.fail_reason = rfc_pkg::REASON_NO_ETX;
				return 1;
			end
			if (fire) begin
				r.data_valid = 1'b1;
				r.data_byte  = sent;
				return 1;
			end
			return 0;
		end
		// verdict given, skip to the end of the buffer
		if (last) begin
			rx_phase = HUNT;
		end
		return 0;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("%0t: %s is %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	// input request driver
	always @(negedge clk) begin
		if (!in_valid || byte_taken) begin
			if (arst_n && rx_pending.size() > 0
					&& (quiet_spell || $urandom_range(0, 99) >= IDLE_PCT)) begin
				in_valid    <= 1'b1;
				rx_byte     <= rx_pending[0].b;
				buffer_last <= rx_pending[0].last;
			end else begin
				in_valid <= 1'b0;
			end
		end
		byte_taken = 0;
	end

	// result receiver with random stalls and the long hold-off
	always @(negedge clk) begin
		out_ready <= !hold_rx && (quiet_spell || $urandom_range(0, 99) >= IDLE_PCT);
	end

	// long receiver hold-off so the result buffer fills and input stalls
	initial begin : squeeze
		wait (squeeze_go);
		@(posedge clk);
		hold_rx = 1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx = 0;
	end

	// accepted requests feed the prediction, accepted results are checked in order
	always @(posedge clk) begin : monitor
		rfc_pkg::res_t due;
		bit            moved;
		if (arst_n) begin
			moved = 0;
			if (in_valid && in_ready) begin
				if (check_rx_byte(rx_byte, buffer_last, due)) begin
					frame_results_due.push_back(due);
				end
				void'(rx_pending.pop_front());
				byte_taken = 1;
				n_bytes++;
				moved = 1;
			end
			if (out_valid && out_ready) begin
				moved = 1;
				if (frame_results_due.size() == 0) begin
					report_mismatch("unexpected result, data_byte", data_byte, 8'h00);
				end else begin
					due = frame_results_due.pop_front();
					if (data_valid !== due.data_valid)
						report_mismatch("data_valid", 8'(data_valid), 8'(due.data_valid));
					if (data_byte !== due.data_byte)
						report_mismatch("data_byte", data_byte, due.data_byte);
					if (frame_done !== due.frame_done)
						report_mismatch("frame_done", 8'(frame_done), 8'(due.frame_done));
					if (frame_ok !== due.frame_ok)
						report_mismatch("frame_ok", 8'(frame_ok), 8'(due.frame_ok));
					if (status_byte !== due.status_byte)
						report_mismatch("status_byte", status_byte, due.status_byte);
					if (fail_reason !== due.fail_reason)
						report_mismatch("fail_reason", 8'(fail_reason), 8'(due.fail_reason));
					if (due.frame_done) begin
						n_verdicts++;
					end else begin
						n_data++;
					end
				end
			end
			// watchdog on cycles with no progress
			quiet_count = moved ? 0 : quiet_count + 1;
			if (quiet_count >= STALL_LIMIT) begin
				$display("no progress for %0d cycles", STALL_LIMIT);
				$display("reply_frame_checker_xor_hex test failed");
				$finish;
			end
		end
	end

	task automatic put_byte(input logic [7:0] b, input logic last);
		rx_req_t req;
		req.b    = b;
		req.last = last;
		rx_pending.push_back(req);
		n_pushed++;
	endtask

	// any byte that keeps a body open
	function automatic logic [7:0] body_char();
		logic [7:0] c;
		do c = 8'($urandom_range(1, 255)); while (c == rfc_pkg::ETX);
		return c;
	endfunction

	// line noise ahead of a frame that neither ends the buffer nor starts a frame
	function automatic logic [7:0] junk_byte();
		logic [7:0] c;
		do c = 8'($urandom_range(1, 255)); while (c == rfc_pkg::STX);
		return c;
	endfunction

	// one whole reply buffer carrying a frame of the given kind
	task automatic put_frame(input int n_data_bytes, input frame_kind_t kind);
		logic [7:0] body[$];
		logic [7:0] ax;
		logic [7:0] st;
		logic [7:0] sum;
		ax = want_axis;
		if (kind == WRONG_AXIS) begin
			do ax = body_char(); while (ax == want_axis);
		end
		body.push_back(ax);
		if ($urandom_range(0, 3) != 0) begin
			st = 8'($urandom_range(0, 255));
			body.push_back(hex_char(st[7:4]));
			body.push_back(hex_char(st[3:0]));
		end else begin
			body.push_back(body_char());
			body.push_back(body_char());
		end
		body.push_back(kind == COLON_DATA ? rfc_pkg::COLON : body_char());
		repeat (n_data_bytes) body.push_back(body_char());
		body.push_back(body_char());
		sum = '0;
		foreach (body[i]) sum = sum ^ body[i];
		if (kind == BAD_SUM) begin
			sum = sum ^ (8'h01 << $urandom_range(0, 7));
		end
		body.push_back(hex_char(sum[7:4]));
		body.push_back(hex_char(sum[3:0]));
		put_byte(rfc_pkg::STX, 1'b0);
		foreach (body[i]) put_byte(body[i], 1'b0);
		if ($urandom_range(0, 2) == 0) begin
			put_byte(rfc_pkg::ETX, 1'b1);
		end else begin
			put_byte(rfc_pkg::ETX, 1'b0);
			repeat ($urandom_range(0, 2)) put_byte(8'($urandom_range(0, 255)), 1'b0);
			put_byte(8'($urandom_range(0, 255)), 1'b1);
		end
	endtask

	// mostly well-formed replies, some short, cut off or pure noise
	task automatic random_traffic(input int n);
		int stop;
		int pick;
		int len;
		stop = n_pushed + n;
		while (n_pushed < stop) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 3)) put_byte(junk_byte(), 1'b0);
			end
			if (pick < 55) begin
				put_frame($urandom_range(0, 12), GOOD_FRAME);
			end else if (pick < 65) begin
				put_frame($urandom_range(0, 12), BAD_SUM);
			end else if (pick < 72) begin
				put_frame($urandom_range(0, 8), COLON_DATA);
			end else if (pick < 78) begin
				put_frame($urandom_range(0, 8), WRONG_AXIS);
			end else if (pick < 85) begin
				// short body
				len = $urandom_range(0, 6);
				put_byte(rfc_pkg::STX, 1'b0);
				for (int i = 0; i < len; i++) put_byte(i == 0 ? want_axis : body_char(), 1'b0);
				put_byte(rfc_pkg::ETX, 1'b1);
			end else if (pick < 92) begin
				// body cut off by nul or by the end of the buffer
				put_byte(rfc_pkg::STX, 1'b0);
				repeat ($urandom_range(0, 9)) put_byte(body_char(), 1'b0);
				if ($urandom_range(0, 1) == 1) begin
					put_byte(rfc_pkg::NUL, 1'b0);
					put_byte(8'($urandom_range(0, 255)), 1'b1);
				end else begin
					put_byte(body_char(), 1'b1);
				end
			end else begin
				repeat ($urandom_range(0, 7)) put_byte(8'($urandom_range(0, 255)), 1'b0);
				put_byte(8'($urandom_range(0, 255)), 1'b1);
			end
		end
	endtask

	task automatic set_axis(input logic [7:0] v);
		@(negedge clk);
		cfg_valid     <= 1'b1;
		expected_axis <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		want_axis = v;
		n_cfg++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until every request is taken and every result has come back
	task automatic drain_wait();
		while (rx_pending.size() != 0 || frame_results_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed cases with the reset axis
		put_byte(rfc_pkg::NUL, 1'b0);
		put_byte(8'h55, 1'b1);
		put_byte(8'hff, 1'b1);
		put_byte(rfc_pkg::STX, 1'b1);
		put_byte(rfc_pkg::STX, 1'b0);
		put_byte(rfc_pkg::ETX, 1'b1);
		put_byte(rfc_pkg::STX, 1'b0);
		put_byte(rfc_pkg::AXIS_RESET, 1'b0);
		put_byte(8'h41, 1'b0);
		put_byte(rfc_pkg::ETX, 1'b1);
		put_frame(2, GOOD_FRAME);
		put_frame(0, GOOD_FRAME);
		put_frame(3, BAD_SUM);
		put_frame(3, COLON_DATA);
		put_frame(3, WRONG_AXIS);
		put_byte(rfc_pkg::STX, 1'b0);
		put_byte(rfc_pkg::AXIS_RESET, 1'b0);
		put_byte(8'hff, 1'b0);
		put_byte(rfc_pkg::NUL, 1'b0);
		put_byte(8'h00, 1'b1);
		put_byte(rfc_pkg::STX, 1'b0);
		put_byte(rfc_pkg::AXIS_RESET, 1'b0);
		put_byte(8'h80, 1'b1);
		drain_wait();

		// all-ones axis, with the long receiver hold-off
		set_axis(8'hff);
		random_traffic(60);
		squeeze_go = 1;
		drain_wait();

		// zero axis: every frame fails
		set_axis(8'h00);
		random_traffic(30);
		drain_wait();

		// axis equal to ETX: an empty body passes the axis check
		set_axis(rfc_pkg::ETX);
		put_byte(rfc_pkg::STX, 1'b0);
		put_byte(rfc_pkg::ETX, 1'b0);
		put_byte(8'h11, 1'b1);
		random_traffic(30);
		drain_wait();

		set_axis(8'($urandom_range(0, 255)));
		random_traffic(50);
		drain_wait();

		// back to the reset axis, a long body saturates the position count
		set_axis(rfc_pkg::AXIS_RESET);
		put_frame(135, GOOD_FRAME);
		random_traffic(60);
		drain_wait();

		$display("%0d bytes sent, %0d data bytes and %0d frame verdicts checked",
			n_bytes, n_data, n_verdicts);
		$display("%0d axis settings, one long output stall, %0d mismatches",
			n_cfg, mismatches);
		if (mismatches == 0) begin
			$display("reply_frame_checker_xor_hex test passed");
		end else begin
			$display("reply_frame_checker_xor_hex test failed");
		end
		$finish;
	end

endmodule

// ----- reply_frame_checker_xor_hex.f -----
hw/rtl/rfc_pkg.sv
hw/rtl/rfc_frame.sv
hw/rtl/rfc_out_buf.sv
hw/rtl/reply_frame_checker_xor_hex.sv
sim/tb_reply_frame_checker_xor_hex.sv
